// ===== rtl/tps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg
// types, codes and character class tables for the pre-tokenizer splitter
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int CpW = 21;

  typedef enum logic [1:0] {
    CLS_LETTER = 2'd0,
    CLS_NUMBER = 2'd1,
    CLS_SPACE  = 2'd2,
    CLS_OTHER  = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LETTER = 3'd1,
    KIND_NUMBER = 3'd2,
    KIND_OTHER  = 3'd3,
    KIND_WS     = 3'd4,
    KIND_PREFIX = 3'd5,
    KIND_CONTR  = 3'd6
  } kind_t;

  localparam logic [CpW-1:0] CP_SPACE = 21'h20;
  localparam logic [CpW-1:0] CP_APOS  = 21'h27;
  localparam logic [CpW-1:0] CP_S     = 21'h73;
  localparam logic [CpW-1:0] CP_T     = 21'h74;
  localparam logic [CpW-1:0] CP_M     = 21'h6D;
  localparam logic [CpW-1:0] CP_D     = 21'h64;
  localparam logic [CpW-1:0] CP_R     = 21'h72;
  localparam logic [CpW-1:0] CP_E     = 21'h65;
  localparam logic [CpW-1:0] CP_V     = 21'h76;
  localparam logic [CpW-1:0] CP_L     = 21'h6C;

  typedef struct packed {
    logic [1:0]             count;
    logic                   flushing;
    logic [2:0][CpW-1:0]    cp;
    logic [2:0][1:0]        cls;
    logic [2:0]             last;
  } win_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] contr;
  } emit_st_t;

  function automatic logic inr(logic [CpW-1:0] cp, int lo, int hi);
    inr = (int'(cp) >= lo) && (int'(cp) <= hi);
  endfunction

  function automatic logic letter_hit(logic [CpW-1:0] c);
    letter_hit =
      inr(c,'h41,'h5A)|inr(c,'h61,'h7A)|inr(c,'hAA,'hAA)|inr(c,'hB5,'hB5)|
      inr(c,'hBA,'hBA)|inr(c,'hC0,'hD6)|inr(c,'hD8,'hF6)|inr(c,'hF8,'h24F)|
      inr(c,'h250,'h2AF)|inr(c,'h2C6,'h2D1)|inr(c,'h2E0,'h2E4)|
      inr(c,'h370,'h377)|inr(c,'h37A,'h37F)|inr(c,'h384,'h386)|inr(c,'h388,'h38A)|
      inr(c,'h38C,'h38C)|inr(c,'h38E,'h3A1)|inr(c,'h3A3,'h3CE)|inr(c,'h3D0,'h3D7)|
      inr(c,'h3DA,'h3FF)|inr(c,'h400,'h52F)|inr(c,'h531,'h556)|inr(c,'h561,'h587)|
      inr(c,'h5D0,'h5EA)|inr(c,'h5F0,'h5F2)|inr(c,'h620,'h64A)|inr(c,'h66E,'h66F)|
      inr(c,'h671,'h6D3)|inr(c,'h6D5,'h6D5)|inr(c,'h710,'h72F)|inr(c,'h74D,'h7A5)|
      inr(c,'h904,'h939)|inr(c,'h958,'h961)|inr(c,'h985,'h98C)|inr(c,'h98F,'h990)|
      inr(c,'h993,'h9A8)|inr(c,'h9AA,'h9B0)|inr(c,'h9B2,'h9B2)|inr(c,'h9B6,'h9B9)|
      inr(c,'h9DC,'h9DD)|inr(c,'h9DF,'h9E1)|inr(c,'hA05,'hA0A)|inr(c,'hA0F,'hA10)|
      inr(c,'hA13,'hA28)|inr(c,'hA2A,'hA30)|inr(c,'hA32,'hA33)|inr(c,'hA35,'hA36)|
      inr(c,'hA38,'hA39)|inr(c,'hA85,'hA8B)|inr(c,'hA8F,'hA91)|inr(c,'hA93,'hAA8)|
      inr(c,'hAAA,'hAB0)|inr(c,'hAB2,'hAB3)|inr(c,'hAB5,'hAB9)|inr(c,'hB05,'hB0C)|
      inr(c,'hB0F,'hB10)|inr(c,'hB13,'hB28)|inr(c,'hB2A,'hB39)|inr(c,'hB85,'hBB9)|
      inr(c,'hC05,'hC0C)|inr(c,'hC0E,'hC10)|inr(c,'hC12,'hC28)|inr(c,'hC2A,'hC39)|
      inr(c,'hC85,'hC8C)|inr(c,'hC8E,'hC90)|inr(c,'hC92,'hCA8)|inr(c,'hCAA,'hCB3)|
      inr(c,'hCB5,'hCB9)|inr(c,'hD05,'hD0C)|inr(c,'hD0E,'hD10)|inr(c,'hD12,'hD28)|
      inr(c,'hD2A,'hD39)|inr(c,'hD85,'hDBB)|inr(c,'hDBD,'hDBD)|inr(c,'hDC0,'hDC6)|
      inr(c,'hE01,'hE30)|inr(c,'hE32,'hE33)|inr(c,'hE40,'hE46)|inr(c,'h1E00,'h1FFF)|
      inr(c,'h2160,'h2182)|inr(c,'h2C60,'h2CE4)|inr(c,'h2D00,'h2D25)|
      inr(c,'h3005,'h3007)|inr(c,'h3021,'h3029)|inr(c,'h3031,'h3035)|
      inr(c,'h3041,'h3096)|inr(c,'h309D,'h309F)|inr(c,'h30A1,'h30FA)|
      inr(c,'h30FC,'h30FF)|inr(c,'h3105,'h312D)|inr(c,'h3131,'h318E)|
      inr(c,'h31A0,'h31BA)|inr(c,'h31F0,'h31FF)|inr(c,'h3400,'h4DBF)|
      inr(c,'h4E00,'h9FFF)|inr(c,'hA000,'hA48C)|inr(c,'hAC00,'hD7A3)|
      inr(c,'hF900,'hFA6D)|inr(c,'hFA70,'hFAD9)|inr(c,'hFB00,'hFB06)|
      inr(c,'hFB13,'hFB17)|inr(c,'hFB1D,'hFB28)|inr(c,'hFB2A,'hFBB1)|
      inr(c,'hFBD3,'hFD3D)|inr(c,'hFD50,'hFDC7)|inr(c,'hFDF0,'hFDFB)|
      inr(c,'hFE70,'hFEFC)|inr(c,'hFF21,'hFF3A)|inr(c,'hFF41,'hFF5A)|
      inr(c,'hFF66,'hFFDC)|inr(c,'h10000,'h1000B)|inr(c,'h10140,'h10174)|
      inr(c,'h10300,'h1031E)|inr(c,'h10330,'h1034A)|inr(c,'h10380,'h1039D)|
      inr(c,'h10400,'h1049D)|inr(c,'h10800,'h10838)|inr(c,'h1D400,'h1D454)|
      inr(c,'h1D456,'h1D49C)|inr(c,'h1D49E,'h1D49F)|inr(c,'h1D4A2,'h1D4A2)|
      inr(c,'h1D4A5,'h1D4A6)|inr(c,'h1D4A9,'h1D4AC)|inr(c,'h1D4AE,'h1D4B9)|
      inr(c,'h1D4BB,'h1D4BB)|inr(c,'h1D4BD,'h1D4C3)|inr(c,'h1D4C5,'h1D505)|
      inr(c,'h1D507,'h1D50A)|inr(c,'h1D50D,'h1D514)|inr(c,'h1D516,'h1D51C)|
      inr(c,'h1D51E,'h1D539)|inr(c,'h1D53B,'h1D53E)|inr(c,'h1D540,'h1D544)|
      inr(c,'h1D546,'h1D546)|inr(c,'h1D54A,'h1D550)|inr(c,'h1D552,'h1D6A5)|
      inr(c,'h1D6A8,'h1D7C2);
  endfunction

  function automatic logic digit_hit(logic [CpW-1:0] c);
    digit_hit =
      inr(c,'h30,'h39)|inr(c,'h660,'h669)|inr(c,'h6F0,'h6F9)|inr(c,'h7C0,'h7C9)|
      inr(c,'h966,'h96F)|inr(c,'h9E6,'h9EF)|inr(c,'hA66,'hA6F)|inr(c,'hAE6,'hAEF)|
      inr(c,'hB66,'hB6F)|inr(c,'hBE6,'hBEF)|inr(c,'hC66,'hC6F)|inr(c,'hCE6,'hCEF)|
      inr(c,'hD66,'hD6F)|inr(c,'hE50,'hE59)|inr(c,'hED0,'hED9)|inr(c,'hF20,'hF29)|
      inr(c,'h1040,'h1049)|inr(c,'h1090,'h1099)|inr(c,'h17E0,'h17E9)|
      inr(c,'h1810,'h1819)|inr(c,'h1B50,'h1B59)|inr(c,'h2070,'h2079)|
      inr(c,'h2080,'h2089)|inr(c,'h2460,'h249B)|inr(c,'hFF10,'hFF19)|
      inr(c,'h1D7CE,'h1D7FF);
  endfunction

  function automatic logic blank_hit(logic [CpW-1:0] c);
    blank_hit =
      inr(c,'h09,'h0D)|inr(c,'h20,'h20)|inr(c,'h85,'h85)|inr(c,'hA0,'hA0)|
      inr(c,'h1680,'h1680)|inr(c,'h2000,'h200A)|inr(c,'h2028,'h2029)|
      inr(c,'h202F,'h202F)|inr(c,'h205F,'h205F)|inr(c,'h3000,'h3000);
  endfunction

  function automatic cls_t classify(logic [CpW-1:0] c);
    if (letter_hit(c)) classify = CLS_LETTER;
    else if (digit_hit(c)) classify = CLS_NUMBER;
    else if (blank_hit(c)) classify = CLS_SPACE;
    else classify = CLS_OTHER;
  endfunction

endpackage

// ===== rtl/tps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_in_if / tps_out_if
// valid/ready channels for codepoint words and classified result words
// ----------------------------------------------------------------------------
interface tps_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic        end_of_text;
  modport source (output valid, codepoint, end_of_text, input ready);
  modport sink   (input valid, codepoint, end_of_text, output ready);
endinterface

interface tps_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] out_codepoint;
  logic [1:0]  char_class;
  logic        piece_start;
  logic        last_of_text;
  modport source (output valid, out_codepoint, char_class, piece_start, last_of_text,
                  input ready);
  modport sink   (input valid, out_codepoint, char_class, piece_start, last_of_text,
                  output ready);
endinterface

// ===== rtl/tps_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_window
// three-entry lookahead window: classifies incoming words and drains on flush
// ----------------------------------------------------------------------------
module tps_window
  import tps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [CpW-1:0]   push_cp,
  input  logic             push_last,
  input  logic             pop,
  output win_t             win
);

  logic [2:0][CpW-1:0] cp_r,   cp_nxt;
  logic [2:0][1:0]     cls_r,  cls_nxt;
  logic [2:0]          last_r, last_nxt;
  logic [1:0]          count_r, count_nxt;
  logic                flush_r, flush_nxt;
  logic [1:0]          wr_idx;

  always_comb begin
    cp_nxt    = cp_r;
    cls_nxt   = cls_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    flush_nxt = flush_r;
    if (pop) begin
      cp_nxt   = {cp_r[2], cp_r[2:1]};
      cls_nxt  = {cls_r[2], cls_r[2:1]};
      last_nxt = {last_r[2], last_r[2:1]};
      if (last_r[0]) flush_nxt = 1'b0;
    end
    wr_idx = count_r - {1'b0, pop};
    if (push) begin
      cp_nxt[wr_idx]   = push_cp;
      cls_nxt[wr_idx]  = classify(push_cp);
      last_nxt[wr_idx] = push_last;
      if (push_last) flush_nxt = 1'b1;
    end
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    cls_r  <= cls_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      count_r <= 2'd0;
      flush_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      flush_r <= flush_nxt;
    end
  end

  assign win.count    = count_r;
  assign win.flushing = flush_r;
  assign win.cp       = cp_r;
  assign win.cls      = cls_r;
  assign win.last     = last_r;

endmodule

// ===== rtl/tps_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_emit
// piece boundary decision for the head of the window and the result register
// ----------------------------------------------------------------------------
module tps_emit
  import tps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  win_t       win,
  output logic       pop,
  output emit_st_t   st,
  tps_out_if.source  out_ch
);

  kind_t          kind_r, kind_nxt;
  logic [1:0]     contr_r, contr_nxt;
  logic           ov_r;
  logic [CpW-1:0] ocp_r;
  logic [1:0]     ocls_r;
  logic           ostart_r, olast_r;
  logic           start;
  logic [1:0]     nafter;
  logic           split;
  kind_t          rk;
  logic [CpW-1:0] c, a, b;

  assign nafter = win.flushing ? (win.count - 2'd1) : 2'd2;
  assign pop    = (win.count == 2'd3 || (win.flushing && win.count != 2'd0)) &&
                  (!ov_r || out_ch.ready);

  always_comb begin
    c         = win.cp[0];
    a         = win.cp[1];
    b         = win.cp[2];
    start     = 1'b0;
    kind_nxt  = kind_r;
    contr_nxt = contr_r;
    split     = (nafter != 2'd0) && (win.cls[1] != CLS_SPACE);
    case (win.cls[0])
      CLS_LETTER: rk = KIND_LETTER;
      CLS_NUMBER: rk = KIND_NUMBER;
      default:    rk = KIND_OTHER;
    endcase
    if (contr_r != 2'd0) begin
      contr_nxt = contr_r - 2'd1;
      if (contr_nxt == 2'd0) kind_nxt = KIND_NONE;
    end else if (win.cls[0] == CLS_SPACE) begin
      if (!(kind_r == KIND_WS && !split)) begin
        start = 1'b1;
        if (split) kind_nxt = (c == CP_SPACE) ? KIND_PREFIX : KIND_NONE;
        else kind_nxt = KIND_WS;
      end
    end else if (kind_r == KIND_PREFIX) begin
      kind_nxt = rk;
    end else if (kind_r != rk) begin
      start    = 1'b1;
      kind_nxt = rk;
      if (c == CP_APOS && nafter != 2'd0) begin
        if (a == CP_S || a == CP_T || a == CP_M || a == CP_D) begin
          contr_nxt = 2'd1;
          kind_nxt  = KIND_CONTR;
        end else if (nafter == 2'd2 &&
                     ((a == CP_R && b == CP_E) || (a == CP_V && b == CP_E) ||
                      (a == CP_L && b == CP_L))) begin
          contr_nxt = 2'd2;
          kind_nxt  = KIND_CONTR;
        end
      end
    end
    if (win.last[0]) begin
      kind_nxt  = KIND_NONE;
      contr_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ocp_r    <= win.cp[0];
      ocls_r   <= win.cls[0];
      ostart_r <= start;
      olast_r  <= win.last[0];
    end
    if (!rst_n) begin
      kind_r  <= KIND_NONE;
      contr_r <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      if (pop) begin
        kind_r  <= kind_nxt;
        contr_r <= contr_nxt;
      end
      if (pop) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.out_codepoint = ocp_r;
  assign out_ch.char_class    = ocls_r;
  assign out_ch.piece_start   = ostart_r;
  assign out_ch.last_of_text  = olast_r;
  assign st.kind              = kind_r;
  assign st.contr             = contr_r;

endmodule

// ===== rtl/text_pretokenizer_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_pretokenizer_splitter
// marks pre-token piece starts in a stream of codepoints
// ----------------------------------------------------------------------------
// in_ch carries one codepoint word per handshake, end_of_text on the final
// codepoint of a text. out_ch gives every codepoint back in order with its
// class, a piece start mark and last_of_text on the final one.
// A codepoint is held until two followers are known: item n+2 enters the
// window, then item n moves to the result register. One word a cycle is
// sustained while the receiver takes every word. On end_of_text the window
// (up to three words) drains one word a cycle through the result register
// while the receiver is ready, and no input is taken until the last word of
// the text has been loaded. The result register decouples the sides: input
// is taken while a finished word waits, until the window is full.
// If the receiver stalls, the result word holds and the window fills, then
// in_ch.ready falls.
// Reset empties the window and closes any open piece.
// ----------------------------------------------------------------------------
module text_pretokenizer_splitter
  import tps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tps_in_if.sink    in_ch,
  tps_out_if.source out_ch
);

  win_t     win;
  logic     pop;
  logic     push;
  emit_st_t st;

  assign in_ch.ready = !win.flushing && (win.count != 2'd3 || pop);
  assign push        = in_ch.valid && in_ch.ready;

  tps_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cp   (in_ch.codepoint),
    .push_last (in_ch.end_of_text),
    .pop       (pop),
    .win       (win)
  );

  tps_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .win    (win),
    .pop    (pop),
    .st     (st),
    .out_ch (out_ch)
  );

  a_contr_range: assert property (@(posedge clk) disable iff (!rst_n)
    st.contr != 2'd3) else $error("contraction count out of range");

  a_contr_kind: assert property (@(posedge clk) disable iff (!rst_n)
    st.contr != 2'd0 |-> st.kind == KIND_CONTR) else $error("contraction without kind");

  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    pop && win.last[0] |=> st.kind == KIND_NONE && st.contr == 2'd0)
    else $error("piece left open after flush");

endmodule

// ===== tb/sv/text_pretokenizer_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_pretokenizer_splitter_tb
// Sends texts of codepoints through the splitter and predicts each result
// word: its codepoint, its class, whether it starts a piece, and whether it
// is the last word of the text. Both sides idle at random, with one long
// stretch that has no idling. The stimulus is mostly word-like texts built
// from letters, numbers, spaces, punctuation and contractions, plus raw
// codepoints over the whole 21-bit range.
// ----------------------------------------------------------------------------
module text_pretokenizer_splitter_tb;
  import tps_pkg::*;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           eot;
  } cp_word_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    cls_t           cls;
    logic           start;
    logic           last;
  } piece_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tps_in_if  in_ch ();
  tps_out_if out_ch ();

  text_pretokenizer_splitter dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  cp_word_t    pending_words[$];
  piece_word_t expected_words[$];
  int          mismatches = 0;
  bit          stim_done = 0;
  bit          calm = 0;

  // predictor state
  logic [CpW-1:0] win_cp[2];
  cls_t           win_cls[2];
  int             win_cnt = 0;
  kind_t          open_kind = KIND_NONE;
  int             contr_left = 0;

  function automatic cls_t class_of(logic [CpW-1:0] c);
    int lt[][2] = '{
      '{'h41,'h5A},'{'h61,'h7A},'{'hAA,'hAA},'{'hB5,'hB5},'{'hBA,'hBA},'{'hC0,'hD6},
      '{'hD8,'hF6},'{'hF8,'h24F},'{'h250,'h2AF},'{'h2C6,'h2D1},'{'h2E0,'h2E4},
      '{'h370,'h377},'{'h37A,'h37F},'{'h384,'h386},'{'h388,'h38A},'{'h38C,'h38C},
      '{'h38E,'h3A1},'{'h3A3,'h3CE},'{'h3D0,'h3D7},'{'h3DA,'h3FF},'{'h400,'h52F},
      '{'h531,'h556},'{'h561,'h587},'{'h5D0,'h5EA},'{'h5F0,'h5F2},'{'h620,'h64A},
      '{'h66E,'h66F},'{'h671,'h6D3},'{'h6D5,'h6D5},'{'h710,'h72F},'{'h74D,'h7A5},
      '{'h904,'h939},'{'h958,'h961},'{'h985,'h98C},'{'h98F,'h990},'{'h993,'h9A8},
      '{'h9AA,'h9B0},'{'h9B2,'h9B2},'{'h9B6,'h9B9},'{'h9DC,'h9DD},'{'h9DF,'h9E1},
      '{'hA05,'hA0A},'{'hA0F,'hA10},'{'hA13,'hA28},'{'hA2A,'hA30},'{'hA32,'hA33},
      '{'hA35,'hA36},'{'hA38,'hA39},'{'hA85,'hA8B},'{'hA8F,'hA91},'{'hA93,'hAA8},
      '{'hAAA,'hAB0},'{'hAB2,'hAB3},'{'hAB5,'hAB9},'{'hB05,'hB0C},'{'hB0F,'hB10},
      '{'hB13,'hB28},'{'hB2A,'hB39},'{'hB85,'hBB9},'{'hC05,'hC0C},'{'hC0E,'hC10},
      '{'hC12,'hC28},'{'hC2A,'hC39},'{'hC85,'hC8C},'{'hC8E,'hC90},'{'hC92,'hCA8},
      '{'hCAA,'hCB3},'{'hCB5,'hCB9},'{'hD05,'hD0C},'{'hD0E,'hD10},'{'hD12,'hD28},
      '{'hD2A,'hD39},'{'hD85,'hDBB},'{'hDBD,'hDBD},'{'hDC0,'hDC6},'{'hE01,'hE30},
      '{'hE32,'hE33},'{'hE40,'hE46},'{'h1E00,'h1FFF},'{'h2160,'h2182},
      '{'h2C60,'h2CE4},'{'h2D00,'h2D25},'{'h3005,'h3007},'{'h3021,'h3029},
      '{'h3031,'h3035},'{'h3041,'h3096},'{'h309D,'h309F},'{'h30A1,'h30FA},
      '{'h30FC,'h30FF},'{'h3105,'h312D},'{'h3131,'h318E},'{'h31A0,'h31BA},
      '{'h31F0,'h31FF},'{'h3400,'h4DBF},'{'h4E00,'h9FFF},'{'hA000,'hA48C},
      '{'hAC00,'hD7A3},'{'hF900,'hFA6D},'{'hFA70,'hFAD9},'{'hFB00,'hFB06},
      '{'hFB13,'hFB17},'{'hFB1D,'hFB28},'{'hFB2A,'hFBB1},'{'hFBD3,'hFD3D},
      '{'hFD50,'hFDC7},'{'hFDF0,'hFDFB},'{'hFE70,'hFEFC},'{'hFF21,'hFF3A},
      '{'hFF41,'hFF5A},'{'hFF66,'hFFDC},'{'h10000,'h1000B},'{'h10140,'h10174},
      '{'h10300,'h1031E},'{'h10330,'h1034A},'{'h10380,'h1039D},'{'h10400,'h1049D},
      '{'h10800,'h10838},'{'h1D400,'h1D454},'{'h1D456,'h1D49C},'{'h1D49E,'h1D49F},
      '{'h1D4A2,'h1D4A2},'{'h1D4A5,'h1D4A6},'{'h1D4A9,'h1D4AC},'{'h1D4AE,'h1D4B9},
      '{'h1D4BB,'h1D4BB},'{'h1D4BD,'h1D4C3},'{'h1D4C5,'h1D505},'{'h1D507,'h1D50A},
      '{'h1D50D,'h1D514},'{'h1D516,'h1D51C},'{'h1D51E,'h1D539},'{'h1D53B,'h1D53E},
      '{'h1D540,'h1D544},'{'h1D546,'h1D546},'{'h1D54A,'h1D550},'{'h1D552,'h1D6A5},
      '{'h1D6A8,'h1D7C2}};
    int nt[][2] = '{
      '{'h30,'h39},'{'h660,'h669},'{'h6F0,'h6F9},'{'h7C0,'h7C9},'{'h966,'h96F},
      '{'h9E6,'h9EF},'{'hA66,'hA6F},'{'hAE6,'hAEF},'{'hB66,'hB6F},'{'hBE6,'hBEF},
      '{'hC66,'hC6F},'{'hCE6,'hCEF},'{'hD66,'hD6F},'{'hE50,'hE59},'{'hED0,'hED9},
      '{'hF20,'hF29},'{'h1040,'h1049},'{'h1090,'h1099},'{'h17E0,'h17E9},
      '{'h1810,'h1819},'{'h1B50,'h1B59},'{'h2070,'h2079},'{'h2080,'h2089},
      '{'h2460,'h249B},'{'hFF10,'hFF19},'{'h1D7CE,'h1D7FF}};
    int st[][2] = '{
      '{'h09,'h0D},'{'h20,'h20},'{'h85,'h85},'{'hA0,'hA0},'{'h1680,'h1680},
      '{'h2000,'h200A},'{'h2028,'h2029},'{'h202F,'h202F},'{'h205F,'h205F},
      '{'h3000,'h3000}};
    int v;
    v = int'(c);
    foreach (lt[k]) if (v >= lt[k][0] && v <= lt[k][1]) return CLS_LETTER;
    foreach (nt[k]) if (v >= nt[k][0] && v <= nt[k][1]) return CLS_NUMBER;
    foreach (st[k]) if (v >= st[k][0] && v <= st[k][1]) return CLS_SPACE;
    return CLS_OTHER;
  endfunction

  // decides one word given up to two followers
  function automatic void mark_word(logic [CpW-1:0] cp[3], cls_t cls[3], int base,
                                    int nafter, bit last);
    piece_word_t w;
    logic [CpW-1:0] c, a, b;
    kind_t rk;
    bit split;
    c = cp[base];
    w.start = 1'b0;
    if (contr_left != 0) begin
      contr_left--;
      if (contr_left == 0) open_kind = KIND_NONE;
    end else if (cls[base] == CLS_SPACE) begin
      split = nafter >= 1 && cls[base+1] != CLS_SPACE;
      if (!(open_kind == KIND_WS && !split)) begin
        w.start = 1'b1;
        if (split) open_kind = (c == CP_SPACE) ? KIND_PREFIX : KIND_NONE;
        else open_kind = KIND_WS;
      end
    end else begin
      rk = (cls[base] == CLS_LETTER) ? KIND_LETTER :
           (cls[base] == CLS_NUMBER) ? KIND_NUMBER : KIND_OTHER;
      if (open_kind == KIND_PREFIX) begin
        open_kind = rk;
      end else if (open_kind != rk) begin
        w.start = 1'b1;
        open_kind = rk;
        if (c == CP_APOS && nafter >= 1) begin
          a = cp[base+1];
          if (a == CP_S || a == CP_T || a == CP_M || a == CP_D) begin
            contr_left = 1;
            open_kind = KIND_CONTR;
          end else if (nafter >= 2) begin
            b = cp[base+2];
            if ((a == CP_R && b == CP_E) || (a == CP_V && b == CP_E) ||
                (a == CP_L && b == CP_L)) begin
              contr_left = 2;
              open_kind = KIND_CONTR;
            end
          end
        end
      end
    end
    w.cp = c;
    w.cls = cls[base];
    w.last = last;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void predict_split(cp_word_t iw);
    logic [CpW-1:0] cp[3];
    cls_t cls[3];
    int tot;
    for (int k = 0; k < win_cnt; k++) begin
      cp[k] = win_cp[k];
      cls[k] = win_cls[k];
    end
    cp[win_cnt] = iw.cp;
    cls[win_cnt] = class_of(iw.cp);
    tot = win_cnt + 1;
    for (int k = tot; k < 3; k++) begin
      cp[k] = '0;
      cls[k] = CLS_LETTER;
    end
    if (iw.eot) begin
      for (int k = 0; k < tot; k++) mark_word(cp, cls, k, tot - 1 - k, k == tot - 1);
      win_cnt = 0;
      open_kind = KIND_NONE;
      contr_left = 0;
    end else if (tot == 3) begin
      mark_word(cp, cls, 0, 2, 1'b0);
      win_cp[0] = cp[1];
      win_cls[0] = cls[1];
      win_cp[1] = cp[2];
      win_cls[1] = cls[2];
      win_cnt = 2;
    end else begin
      for (int k = 0; k < tot; k++) begin
        win_cp[k] = cp[k];
        win_cls[k] = cls[k];
      end
      win_cnt = tot;
    end
  endfunction

  function automatic logic [CpW-1:0] pick_char();
    logic [CpW-1:0] pool[] = '{21'h61, 21'h73, 21'h74, 21'h6D, 21'h64, 21'h72, 21'h65,
      21'h76, 21'h6C, 21'h41, 21'h30, 21'h39, 21'h20, 21'h20, 21'h20, 21'h0A, 21'h09,
      21'h27, 21'h27, 21'h2E, 21'h21, 21'h4E00, 21'h3000, 21'h1D7CE, 21'h2000};
    case ($urandom_range(0, 9))
      0: return logic'($urandom) ? CpW'($urandom_range(0, 'h1FFFFF)) :
                                   CpW'($urandom_range(0, 'h3100));
      default: return pool[$urandom_range(0, pool.size() - 1)];
    endcase
  endfunction

  task automatic push_text(logic [CpW-1:0] cps[$]);
    cp_word_t w;
    foreach (cps[k]) begin
      w.cp = cps[k];
      w.eot = (k == cps.size() - 1);
      pending_words.insert(pending_words.size(), w);
    end
  endtask

  // stimulus
  initial begin
    logic [CpW-1:0] t[$];
    int n;
    push_text('{21'h1FFFFF});
    push_text('{21'h0});
    push_text('{21'h27, 21'h73});
    push_text('{21'h27, 21'h72, 21'h65, 21'h20, 21'h27, 21'h6C, 21'h6C});
    push_text('{21'h27, 21'h72});
    push_text('{21'h2E, 21'h27, 21'h74, 21'h20, 21'h27, 21'h64});
    push_text('{21'h20, 21'h20, 21'h20, 21'h61, 21'h0A, 21'h20});
    push_text('{21'h110000, 21'h31, 21'h4E00, 21'h1D7CE, 21'h3000, 21'h27, 21'h76,
                21'h65});
    n = 0;
    while (n < 500) begin
      t.delete();
      repeat ($urandom_range(1, 14)) t.insert(t.size(), pick_char());
      push_text(t);
      n += t.size();
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.codepoint <= '0;
      in_ch.end_of_text <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_split('{in_ch.codepoint, in_ch.end_of_text});
        void'(pending_words.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          in_ch.valid <= 1'b1;
          in_ch.codepoint <= pending_words[0].cp;
          in_ch.end_of_text <= pending_words[0].eot;
        end else begin
          in_ch.valid <= 1'b0;
          if (pending_words.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    piece_word_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || $urandom_range(0, 99) >= 15;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_codepoint, cls_t'(out_ch.char_class), out_ch.piece_start,
                out_ch.last_of_text};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word cp=%h", got.cp);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp cp=%h cls=%0d st=%b last=%b ",
                        "got cp=%h cls=%0d st=%b last=%b"},
                       want.cp, want.cls, want.start, want.last,
                       got.cp, got.cls, got.start, got.last);
          end
        end
      end
    end
  end

  // long calm stretch in the middle
  initial begin
    #2500 calm = 1'b1;
    #2000 calm = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && pending_words.size() == 0 && !in_ch.valid);
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("text_pretokenizer_splitter_tb: clean");
    end else begin
      $display("text_pretokenizer_splitter_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("text_pretokenizer_splitter_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tps_pkg.sv
rtl/tps_if.sv
rtl/tps_window.sv
rtl/tps_emit.sv
rtl/text_pretokenizer_splitter.sv
tb/sv/text_pretokenizer_splitter_tb.sv
